@@ hdl/assert_macros.svh @@
// Assertion macros shared by the motor position PID axis RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mpp_pkg.sv @@
// Package for the motor position PID axis: widths, constants, codes and
// the structs passed between the top level, the sequencer and the multiplier.
// No dependencies.
`default_nettype none

package mpp_pkg;

   localparam int RAW_W      = 16;
   localparam int POS_W      = 32;
   localparam int DUTY_W     = 19;
   localparam int CMP_W      = 13;
   localparam int VEL_W      = 32;
   localparam int GAIN_W     = 24;
   localparam int LIM_W      = 18;
   localparam int DB_W       = 16;
   localparam int STEP_W     = 32;
   localparam int INV_W      = 2;
   localparam int RAMP_W     = 48;
   localparam int ERR_W      = 49;
   localparam int INTEG_W    = 20;
   localparam int ACC_W      = 64;
   localparam int MAG_W      = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 104;

   localparam logic [GAIN_W-1:0]         ALPHA_Q16      = 24'd3277;
   localparam logic [GAIN_W-1:0]         PWM_FULL_SCALE = 24'd4199;
   localparam logic signed [INTEG_W-1:0] ISTEP_MAX      = 20'sd262144;
   localparam logic [MAG_W-1:0]          DUTY_ONE       = 17'd65536;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_POS  = 2'd1,
      MODE_OPEN = 2'd2,
      MODE_BUSY = 2'd3
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_INTEGRAL_GAIN  = 3'd1,
      REG_DERIV_GAIN     = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_OUTPUT_LIMIT   = 3'd4,
      REG_DEADBAND       = 3'd5,
      REG_MAX_STEP       = 3'd6,
      REG_INVERT_FLAGS   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_HOLD,
      MUL_LO,
      MUL_MID,
      MUL_HI
   } mul_op_type;

   typedef struct packed {
      mul_op_type op;
      logic       round_up;
   } mul_cmd_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integral_gain_per_tick;
      logic [GAIN_W-1:0] deriv_gain_per_tick;
      logic [LIM_W-1:0]  integral_limit;
      logic [LIM_W-1:0]  output_limit;
      logic [DB_W-1:0]   deadband_counts;
      logic [STEP_W-1:0] max_step;
      logic [INV_W-1:0]  invert_flags;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0]         raw_count;
      mode_type                 mode;
      logic signed [POS_W-1:0]  target_position;
      logic signed [DUTY_W-1:0] open_loop_duty;
      logic                     rezero;
      logic signed [POS_W-1:0]  rezero_position;
   } req_type;

   typedef struct packed {
      logic [CMP_W-1:0]         compare_value;
      logic                     drive_a;
      logic                     drive_b;
      logic signed [DUTY_W-1:0] effort;
      logic signed [POS_W-1:0]  logical_position;
      logic signed [VEL_W-1:0]  velocity;
      logic                     saturated;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/motor_position_pid_axis.sv @@
// Channel  Dir  Word                                   Taken when
// req_     in   raw count, mode, setpoint, duty, rezero req_tvalid & req_tready
// rsp_     out  compare, pins, effort, position, vel.  rsp_tvalid & rsp_tready
// csr_     in   register index and value               csr_we
// A word runs to its result before the next word is accepted; one shared
// multiplier makes each gain product in three slice passes, up to four
// products per position tick.
// Synchronous reset loads register defaults and zeroes loop state; no clear pass.
// A waiting result sits in the output register while the next word is taken;
// a word only finishes once that register is free.
// Depends on mpp_pkg and mpp_ctrl.
`default_nettype none

module motor_position_pid_axis
   import mpp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // raw_count[15:0], mode[17:16], target_position[49:18],
   // open_loop_duty[68:50], rezero[69], rezero_position[101:70]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // compare_value[12:0], drive_a[13], drive_b[14], effort[33:15],
   // logical_position[65:34], velocity[97:66], saturated[98]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                 cfg_ff, cfg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   req_type                 req;
   rsp_type                 rsp;
   logic                    idle;
   logic                    done;
   logic                    out_free;

   always_comb begin
      req.raw_count       = req_tdata[15:0];
      req.mode            = mode_type'(req_tdata[17:16]);
      req.target_position = req_tdata[49:18];
      req.open_loop_duty  = req_tdata[68:50];
      req.rezero          = req_tdata[69];
      req.rezero_position = req_tdata[101:70];
   end

   assign req_tready = idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   mpp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && idle),
      .req      (req),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (idle),
      .done     (done),
      .rsp      (rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_PROP_GAIN:      cfg_in.prop_gain              = csr_wdata[GAIN_W-1:0];
            REG_INTEGRAL_GAIN:  cfg_in.integral_gain_per_tick = csr_wdata[GAIN_W-1:0];
            REG_DERIV_GAIN:     cfg_in.deriv_gain_per_tick    = csr_wdata[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit         = csr_wdata[LIM_W-1:0];
            REG_OUTPUT_LIMIT:   cfg_in.output_limit           = csr_wdata[LIM_W-1:0];
            REG_DEADBAND:       cfg_in.deadband_counts        = csr_wdata[DB_W-1:0];
            REG_MAX_STEP:       cfg_in.max_step               = csr_wdata[STEP_W-1:0];
            REG_INVERT_FLAGS:   cfg_in.invert_flags           = csr_wdata[INV_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b00000, rsp.saturated, rsp.velocity, rsp.logical_position,
                         rsp.effort, rsp.drive_b, rsp.drive_a, rsp.compare_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain              <= 24'd6554;
         cfg_ff.integral_gain_per_tick <= '0;
         cfg_ff.deriv_gain_per_tick    <= '0;
         cfg_ff.integral_limit         <= 18'd16384;
         cfg_ff.output_limit           <= 18'd65536;
         cfg_ff.deadband_counts        <= 16'd2;
         cfg_ff.max_step               <= '0;
         cfg_ff.invert_flags           <= '0;
         rsp_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/mpp_mul.sv @@
// Shared multiply-accumulate unit: gain times one 16/17-bit slice of a
// 49-bit operand per cycle, accumulated into a Q16-scaled result.
// Depends on mpp_pkg.
`default_nettype none

module mpp_mul
   import mpp_pkg::*;
(
   input  wire logic                    clock,
   input  wire mul_cmd_type             cmd,
   input  wire logic [GAIN_W-1:0]       gain,
   input  wire logic signed [ERR_W-1:0] operand,
   output logic signed [ACC_W-1:0]      acc
);

   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [16:0]         chunk;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [GAIN_W+17:0]  prod;
   logic signed [GAIN_W+17:0]  lo_sum;

   always_comb begin
      case (cmd.op)
         MUL_HI:  chunk = operand[ERR_W-1:32];
         MUL_MID: chunk = {1'b0, operand[31:16]};
         default: chunk = {1'b0, operand[15:0]};
      endcase
      gain_s = {1'b0, gain};
      prod   = gain_s * chunk;
      lo_sum = prod + (cmd.round_up ? (GAIN_W+18)'(32768) : (GAIN_W+18)'(0));
      case (cmd.op)
         MUL_LO:  acc_in = ACC_W'(lo_sum >>> 16);
         MUL_MID: acc_in = acc_ff + ACC_W'(prod);
         MUL_HI:  acc_in = acc_ff + (ACC_W'(prod) <<< 16);
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ hdl/mpp_ctrl.sv @@
// Tick sequencer for the motor position PID axis: loop state, encoder fold,
// filter, ramp, PID terms and clamps, driving the shared multiplier.
// Depends on mpp_pkg, mpp_mul and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mpp_ctrl
   import mpp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req,
   input  wire cfg_type cfg,
   input  wire logic    out_free,
   output logic         idle,
   output logic         done,
   output rsp_type      rsp
);

   typedef enum logic [4:0] {
      S_IDLE, S_PREP, S_FOLD, S_VM0, S_VM1, S_VM2, S_VUPD,
      S_RAMP1, S_RAMP2, S_ERR, S_DB,
      S_IM0, S_IM1, S_IM2, S_ISTEP, S_IACC,
      S_PM0, S_PM1, S_PM2, S_PACC,
      S_DM0, S_DM1, S_DM2, S_DACC,
      S_SAT, S_CMP, S_DONE
   } state_type;

   localparam logic signed [ACC_W-1:0] VEL_MAX  = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] VEL_MIN  = -ACC_W'(64'sh8000_0000);
   localparam logic signed [ACC_W-1:0] ISTEP_HI = ACC_W'(ISTEP_MAX);

   state_type                  state_ff, state_in;
   req_type                    req_ff, req_in;
   logic [RAW_W-1:0]           last_raw_ff, last_raw_in;
   logic [POS_W-1:0]           raw_pos_ff, raw_pos_in;
   logic signed [RAMP_W-1:0]   ramp_ff, ramp_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [VEL_W-1:0]    fvel_ff, fvel_in;
   mode_type                   prev_mode_ff, prev_mode_in;
   logic                       sat_ff, sat_in;
   logic signed [ERR_W-1:0]    xop_ff, xop_in;
   logic signed [INTEG_W-1:0]  istep_ff, istep_in;
   logic signed [ACC_W-1:0]    o_ff, o_in;
   logic signed [DUTY_W-1:0]   duty_ff, duty_in;

   logic signed [POS_W-1:0]    lp;
   logic signed [RAW_W-1:0]    delta;
   logic signed [RAW_W:0]      delta_x;
   logic signed [RAW_W:0]      ldelta;
   logic signed [ACC_W-1:0]    vsum;
   logic signed [RAMP_W-1:0]   tq;
   logic signed [ERR_W-1:0]    ms;
   logic signed [ERR_W-1:0]    step;
   logic signed [ERR_W-1:0]    dbq;
   logic signed [INTEG_W:0]    isum;
   logic signed [INTEG_W:0]    ilim;
   logic signed [ACC_W-1:0]    olim;
   logic [DUTY_W-1:0]          dabs;
   logic [MAG_W-1:0]           mag;
   logic                       fwd;

   mul_cmd_type                mul_cmd;
   logic [GAIN_W-1:0]          mul_gain;
   logic signed [ERR_W-1:0]    mul_operand;
   logic signed [ACC_W-1:0]    acc;

   mpp_mul u_mul (
      .clock   (clock),
      .cmd     (mul_cmd),
      .gain    (mul_gain),
      .operand (mul_operand),
      .acc     (acc)
   );

   // shared derived values
   always_comb begin
      lp      = cfg.invert_flags[0] ? -raw_pos_ff : raw_pos_ff;
      delta   = req_ff.raw_count - last_raw_ff;
      delta_x = {delta[RAW_W-1], delta};
      ldelta  = cfg.invert_flags[0] ? -delta_x : delta_x;
      vsum    = ACC_W'(fvel_ff) + acc;
      tq      = $signed({req_ff.target_position, 16'h0000});
      ms      = $signed(ERR_W'(cfg.max_step));
      dbq     = $signed(ERR_W'({cfg.deadband_counts, 16'h0000}));
      isum    = (INTEG_W+1)'(istep_ff) + (INTEG_W+1)'(integ_ff);
      ilim    = $signed({3'b000, cfg.integral_limit});
      olim    = $signed(ACC_W'(cfg.output_limit));
      dabs    = duty_ff[DUTY_W-1] ? -duty_ff : duty_ff;
      mag     = (dabs > DUTY_W'(DUTY_ONE)) ? DUTY_ONE : dabs[MAG_W-1:0];
      if (xop_ff > ms) begin
         step = ms;
      end else if (xop_ff < -ms) begin
         step = -ms;
      end else begin
         step = xop_ff;
      end
   end

   // multiplier command per state
   always_comb begin
      mul_cmd.op       = MUL_HOLD;
      mul_cmd.round_up = 1'b1;
      mul_gain         = cfg.prop_gain;
      mul_operand      = xop_ff;
      case (state_ff)
         S_VM0, S_IM0, S_PM0, S_DM0: mul_cmd.op = MUL_LO;
         S_VM1, S_IM1, S_PM1, S_DM1: mul_cmd.op = MUL_MID;
         S_VM2, S_IM2, S_PM2, S_DM2: mul_cmd.op = MUL_HI;
         S_CMP: begin
            mul_cmd.op       = MUL_LO;
            mul_cmd.round_up = 1'b0;
         end
         default: mul_cmd.op = MUL_HOLD;
      endcase
      case (state_ff)
         S_VM0, S_VM1, S_VM2: mul_gain = ALPHA_Q16;
         S_IM0, S_IM1, S_IM2: mul_gain = cfg.integral_gain_per_tick;
         S_DM0, S_DM1, S_DM2: mul_gain = cfg.deriv_gain_per_tick;
         S_CMP:               mul_gain = PWM_FULL_SCALE;
         default:             mul_gain = cfg.prop_gain;
      endcase
      case (state_ff)
         S_DM0, S_DM1, S_DM2: mul_operand = ERR_W'(fvel_ff);
         S_CMP:               mul_operand = $signed(ERR_W'(mag));
         default:             mul_operand = xop_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      last_raw_in  = last_raw_ff;
      raw_pos_in   = raw_pos_ff;
      ramp_in      = ramp_ff;
      integ_in     = integ_ff;
      fvel_in      = fvel_ff;
      prev_mode_in = prev_mode_ff;
      sat_in       = sat_ff;
      xop_in       = xop_ff;
      istep_in     = istep_ff;
      o_in         = o_ff;
      duty_in      = duty_ff;
      done         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (req_ff.rezero) begin
               raw_pos_in  = cfg.invert_flags[0] ? -req_ff.rezero_position
                                                 : req_ff.rezero_position;
               last_raw_in = req_ff.raw_count;
               ramp_in     = $signed({req_ff.rezero_position, 16'h0000});
               integ_in    = '0;
               fvel_in     = '0;
            end
            if (req_ff.mode == MODE_POS && prev_mode_ff != MODE_POS) begin
               ramp_in  = req_ff.rezero ? $signed({req_ff.rezero_position, 16'h0000})
                                        : $signed({lp, 16'h0000});
               integ_in = '0;
            end
            prev_mode_in = req_ff.mode;
            state_in     = S_FOLD;
         end
         S_FOLD: begin
            last_raw_in = req_ff.raw_count;
            raw_pos_in  = raw_pos_ff + {{(POS_W-RAW_W){delta[RAW_W-1]}}, delta};
            xop_in      = ERR_W'($signed({ldelta, 16'h0000})) - ERR_W'(fvel_ff);
            state_in    = S_VM0;
         end
         S_VM0: state_in = S_VM1;
         S_VM1: state_in = S_VM2;
         S_VM2: state_in = S_VUPD;
         S_VUPD: begin
            if (vsum > VEL_MAX) begin
               fvel_in = VEL_W'(VEL_MAX);
            end else if (vsum < VEL_MIN) begin
               fvel_in = VEL_W'(VEL_MIN);
            end else begin
               fvel_in = VEL_W'(vsum);
            end
            if (req_ff.mode == MODE_POS) begin
               state_in = S_RAMP1;
            end else begin
               integ_in = '0;
               ramp_in  = $signed({lp, 16'h0000});
               if (req_ff.mode == MODE_OPEN) begin
                  duty_in = req_ff.open_loop_duty;
               end else begin
                  duty_in = '0;
                  sat_in  = 1'b0;
               end
               state_in = S_CMP;
            end
         end
         S_RAMP1: begin
            xop_in = ERR_W'(tq) - ERR_W'(ramp_ff);
            if (cfg.max_step == '0) begin
               ramp_in  = tq;
               state_in = S_ERR;
            end else begin
               state_in = S_RAMP2;
            end
         end
         S_RAMP2: begin
            ramp_in  = RAMP_W'(ERR_W'(ramp_ff) + step);
            state_in = S_ERR;
         end
         S_ERR: begin
            xop_in   = ERR_W'(ramp_ff) - ERR_W'($signed({lp, 16'h0000}));
            state_in = S_DB;
         end
         S_DB: begin
            if (xop_ff < dbq && xop_ff > -dbq) begin
               integ_in = '0;
               sat_in   = 1'b0;
               duty_in  = '0;
               state_in = S_CMP;
            end else begin
               state_in = S_IM0;
            end
         end
         S_IM0: state_in = S_IM1;
         S_IM1: state_in = S_IM2;
         S_IM2: state_in = S_ISTEP;
         S_ISTEP: begin
            if (acc > ISTEP_HI) begin
               istep_in = ISTEP_MAX;
            end else if (acc < -ISTEP_HI) begin
               istep_in = -ISTEP_MAX;
            end else begin
               istep_in = INTEG_W'(acc);
            end
            state_in = S_IACC;
         end
         S_IACC: begin
            if (isum > ilim) begin
               integ_in = INTEG_W'(ilim);
            end else if (isum < -ilim) begin
               integ_in = INTEG_W'(-ilim);
            end else begin
               integ_in = INTEG_W'(isum);
            end
            state_in = S_PM0;
         end
         S_PM0: state_in = S_PM1;
         S_PM1: state_in = S_PM2;
         S_PM2: state_in = S_PACC;
         S_PACC: begin
            o_in     = acc + ACC_W'(integ_ff);
            state_in = S_DM0;
         end
         S_DM0: state_in = S_DM1;
         S_DM1: state_in = S_DM2;
         S_DM2: state_in = S_DACC;
         S_DACC: begin
            o_in     = o_ff - acc;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (o_ff > olim) begin
               duty_in  = DUTY_W'(olim);
               sat_in   = 1'b1;
               integ_in = integ_ff - istep_ff;
            end else if (o_ff < -olim) begin
               duty_in  = DUTY_W'(-olim);
               sat_in   = 1'b1;
               integ_in = integ_ff - istep_ff;
            end else begin
               duty_in  = DUTY_W'(o_ff);
               sat_in   = 1'b0;
            end
            state_in = S_CMP;
         end
         S_CMP: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_raw_ff  <= '0;
         raw_pos_ff   <= '0;
         ramp_ff      <= '0;
         integ_ff     <= '0;
         fvel_ff      <= '0;
         prev_mode_ff <= MODE_OFF;
         sat_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_raw_ff  <= last_raw_in;
         raw_pos_ff   <= raw_pos_in;
         ramp_ff      <= ramp_in;
         integ_ff     <= integ_in;
         fvel_ff      <= fvel_in;
         prev_mode_ff <= prev_mode_in;
         sat_ff       <= sat_in;
      end
      req_ff   <= req_in;
      xop_ff   <= xop_in;
      istep_ff <= istep_in;
      o_ff     <= o_in;
      duty_ff  <= duty_in;
   end

   always_comb begin
      fwd                  = (duty_ff > 0) ^ cfg.invert_flags[1];
      idle                 = (state_ff == S_IDLE);
      rsp.compare_value    = mag[MAG_W-1] ? CMP_W'(PWM_FULL_SCALE) : acc[CMP_W-1:0];
      rsp.drive_a          = fwd;
      rsp.drive_b          = !fwd;
      rsp.effort           = duty_ff;
      rsp.logical_position = lp;
      rsp.velocity         = fvel_ff;
      rsp.saturated        = sat_ff;
   end

   `ASSERT_ALWAYS(a_reset_to_idle, clock, reset |=> (state_ff == S_IDLE), "not idle after reset")
   `ASSERT_CLK(a_integ_clear_off, clock, reset, (idle && prev_mode_ff != MODE_POS) |-> (integ_ff == '0), "integral held outside position mode")
   `ASSERT_CLK(a_sat_clear_off, clock, reset, (idle && (prev_mode_ff == MODE_OFF || prev_mode_ff == MODE_BUSY)) |-> !sat_ff, "saturated flag set while off")
   `ASSERT_CLK(a_duty_in_limit, clock, reset, (done && req_ff.mode == MODE_POS) |-> (duty_ff <= olim && duty_ff >= -olim), "position duty beyond output limit")
   `ASSERT_CLK(a_compare_range, clock, reset, done |-> (rsp.compare_value <= CMP_W'(PWM_FULL_SCALE)), "compare value above full scale")

endmodule

`default_nettype wire

@@ tb/tb_motor_position_pid_axis.sv @@
// Testbench for motor_position_pid_axis: a directed table, then random control ticks
// under several register settings, checked against a tick predictor or a typed row.
// Depends on mpp_pkg and the motor_position_pid_axis RTL.
`timescale 1ns / 100ps

module tb_motor_position_pid_axis;
   import mpp_pkg::*;

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_style_type;

   localparam rsp_type IDLE_RSP = '{13'd0, 1'b0, 1'b1, 19'sd0, 32'sd0, 32'sd0, 1'b0};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted axis state and registers
   cfg_type     cfg;
   logic [15:0] enc_last;
   logic [31:0] enc_pos;
   longint      ramp_q16;
   longint      integ_q16;
   longint      vel_q16;
   mode_type    mode_prev;
   logic        sat_now;

   rsp_type          tick_results[$];
   directed_row_type plan[$];
   int               mismatches   = 0;
   int               results_seen = 0;
   int               burst_left   = 0;
   int               stall_left   = 0;
   ready_style_type  ready_style  = READY_ALWAYS;
   logic [15:0]      enc_now      = '0;
   mode_type         cur_mode     = MODE_POS;
   logic signed [31:0] target_now = '0;
   rsp_type          got_rsp;
   rsp_type          want_rsp;

   motor_position_pid_axis u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void reset_axis_model();
      cfg = '{24'd6554, 24'd0, 24'd0, 18'd16384, 18'd65536, 16'd2, 32'd0, 2'd0};
      enc_last  = '0;
      enc_pos   = '0;
      ramp_q16  = 0;
      integ_q16 = 0;
      vel_q16   = 0;
      mode_prev = MODE_OFF;
      sat_now   = 1'b0;
   endfunction

   // g * x / 65536, nearest, halves up
   function automatic longint gain_mul(input longint g, input longint x);
      longint hi, lo;
      hi = x >>> 16;
      lo = x - (hi <<< 16);
      return g * hi + ((g * lo + 32768) >>> 16);
   endfunction

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint pos_counts();
      logic [31:0] p;
      p = cfg.invert_flags[0] ? 32'd0 - enc_pos : enc_pos;
      return longint'(signed'(p));
   endfunction

   function automatic rsp_type predict_tick(input req_type w);
      rsp_type            r;
      logic signed [15:0] step16;
      longint             delta, ldelta, v, tgt_q16, err, istep, o, olim, duty, mag;
      logic               fwd;
      duty = 0;
      if (w.rezero) begin
         enc_pos   = cfg.invert_flags[0] ? 32'd0 - w.rezero_position : w.rezero_position;
         enc_last  = w.raw_count;
         ramp_q16  = longint'(w.rezero_position) * 65536;
         integ_q16 = 0;
         vel_q16   = 0;
      end
      if (w.mode == MODE_POS && mode_prev != MODE_POS) begin
         ramp_q16  = pos_counts() * 65536;
         integ_q16 = 0;
      end
      mode_prev = w.mode;

      step16   = w.raw_count - enc_last;
      delta    = step16;
      enc_last = w.raw_count;
      enc_pos  = enc_pos + 32'(delta);
      ldelta   = cfg.invert_flags[0] ? -delta : delta;
      v = vel_q16 + gain_mul(longint'(ALPHA_Q16), ldelta * 65536 - vel_q16);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      vel_q16 = v;

      if (w.mode == MODE_POS) begin
         tgt_q16 = longint'(w.target_position) * 65536;
         if (cfg.max_step != 0)
            ramp_q16 += clamp_sym(tgt_q16 - ramp_q16, longint'(cfg.max_step));
         else
            ramp_q16 = tgt_q16;
         err = ramp_q16 - pos_counts() * 65536;
         if ((err < 0 ? -err : err) < longint'(cfg.deadband_counts) * 65536) begin
            integ_q16 = 0;
            sat_now   = 1'b0;
         end else begin
            istep = clamp_sym(gain_mul(longint'(cfg.integral_gain_per_tick), err),
                              longint'(ISTEP_MAX));
            integ_q16 = clamp_sym(integ_q16 + istep, longint'(cfg.integral_limit));
            o = gain_mul(longint'(cfg.prop_gain), err) + integ_q16
                - gain_mul(longint'(cfg.deriv_gain_per_tick), vel_q16);
            olim = longint'(cfg.output_limit);
            if (o > olim || o < -olim) begin
               o = clamp_sym(o, olim);
               sat_now = 1'b1;
               integ_q16 -= istep;
            end else begin
               sat_now = 1'b0;
            end
            duty = o;
         end
      end else begin
         integ_q16 = 0;
         ramp_q16  = pos_counts() * 65536;
         if (w.mode == MODE_OPEN) begin
            duty = w.open_loop_duty;
         end else begin
            sat_now = 1'b0;
         end
      end

      fwd = duty > 0;
      mag = duty < 0 ? -duty : duty;
      if (mag > longint'(DUTY_ONE)) mag = longint'(DUTY_ONE);
      if (cfg.invert_flags[1]) fwd = !fwd;
      r.compare_value    = 13'((mag * longint'(PWM_FULL_SCALE)) >>> 16);
      r.drive_a          = fwd;
      r.drive_b          = !fwd;
      r.effort           = 19'(duty);
      r.logical_position = 32'(pos_counts());
      r.velocity         = 32'(vel_q16);
      r.saturated        = sat_now;
      return r;
   endfunction

   function automatic void add_row(input logic [15:0] raw, input mode_type md,
                                   input logic signed [31:0] tgt,
                                   input logic signed [18:0] duty, input logic rz,
                                   input logic signed [31:0] rzpos, input bit typed = 1'b0,
                                   input rsp_type want = '0);
      directed_row_type row;
      row.w.raw_count       = raw;
      row.w.mode            = md;
      row.w.target_position = tgt;
      row.w.open_loop_duty  = duty;
      row.w.rezero          = rz;
      row.w.rezero_position = rzpos;
      row.typed             = typed;
      row.want              = want;
      plan.push_back(row);
   endfunction

   function automatic cfg_type random_settings(input int ph);
      cfg_type c;
      int      roll;
      case (ph)
         0: c = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF, 18'd131072, 16'hFFFF,
                  32'hFFFFFFFF, 2'd3};
         1: c = '0;
         2: c = '{24'd6554, 24'd0, 24'd0, 18'd16384, 18'd65536, 16'd2, 32'd0, 2'd0};
         default: begin
            c.prop_gain = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 200000));
            c.integral_gain_per_tick = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 4000));
            c.deriv_gain_per_tick = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 20000));
            c.integral_limit  = 18'($urandom_range(0, 131072));
            c.output_limit    = 18'($urandom_range(0, 131072));
            c.deadband_counts = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 8));
            roll = $urandom_range(0, 2);
            c.max_step = (roll == 0) ? 32'd0 :
                         (roll == 1) ? 32'($urandom_range(1, 1 << 22)) : 32'($urandom);
            c.invert_flags = 2'(ph);
         end
      endcase
      return c;
   endfunction

   // mostly small encoder steps and setpoints near the position, some noise
   function automatic req_type random_tick();
      req_type w;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         enc_now = enc_now + 16'(int'($urandom_range(0, 40)) - 20);
      else if (roll < 95)
         enc_now = enc_now + 16'(int'($urandom_range(0, 4000)) - 2000);
      else
         enc_now = 16'($urandom);
      if ($urandom_range(0, 19) == 0)
         cur_mode = ($urandom_range(0, 99) < 60) ? MODE_POS : mode_type'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 60)
         target_now = 32'(pos_counts() + longint'($urandom_range(0, 400)) - 200);
      else if (roll < 85)
         target_now = target_now + int'($urandom_range(0, 64)) - 32;
      else if (roll < 95)
         target_now = $urandom;
      else
         target_now = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      w.raw_count       = enc_now;
      w.mode            = cur_mode;
      w.target_position = target_now;
      roll = $urandom_range(0, 19);
      w.open_loop_duty = (roll == 0) ? 19'sh20000 :
                         (roll == 1) ? -19'sd131072 :
                         19'(int'($urandom_range(0, 262144)) - 131072);
      w.rezero = ($urandom_range(0, 39) == 0);
      w.rezero_position = $urandom_range(0, 1) ? 32'($urandom)
                          : 32'(pos_counts() + longint'($urandom_range(0, 2000)) - 1000);
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t ns: result %0d: %s", $time, results_seen, what);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic load_settings(input cfg_type c);
      logic [CSR_DATA_W-1:0] value;
      for (int i = 0; i <= int'(REG_INVERT_FLAGS); i++) begin
         case (csr_index_type'(i))
            REG_PROP_GAIN:      value = 32'(c.prop_gain);
            REG_INTEGRAL_GAIN:  value = 32'(c.integral_gain_per_tick);
            REG_DERIV_GAIN:     value = 32'(c.deriv_gain_per_tick);
            REG_INTEGRAL_LIMIT: value = 32'(c.integral_limit);
            REG_OUTPUT_LIMIT:   value = 32'(c.output_limit);
            REG_DEADBAND:       value = 32'(c.deadband_counts);
            REG_MAX_STEP:       value = c.max_step;
            REG_INVERT_FLAGS:   value = 32'(c.invert_flags);
         endcase
         csr_we    <= 1'b1;
         csr_addr  <= csr_index_type'(i);
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg = c;
   endtask

   task automatic send_word(input req_type w, input bit typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type pred;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tdata  <= {2'b0, w.rezero_position, w.rezero, w.open_loop_duty,
                     w.target_position, w.mode, w.raw_count};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pred = predict_tick(w);
      tick_results.push_back(typed ? want : pred);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 2));
         stall_left  = $urandom_range(20, 200);
      end
      stall_left--;
      case (ready_style)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (tick_results.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want_rsp = tick_results.pop_front();
            got_rsp.compare_value    = rsp_tdata[12:0];
            got_rsp.drive_a          = rsp_tdata[13];
            got_rsp.drive_b          = rsp_tdata[14];
            got_rsp.effort           = rsp_tdata[33:15];
            got_rsp.logical_position = rsp_tdata[65:34];
            got_rsp.velocity         = rsp_tdata[97:66];
            got_rsp.saturated        = rsp_tdata[98];
            check_field("compare_value", got_rsp.compare_value, want_rsp.compare_value);
            check_field("drive_a", got_rsp.drive_a, want_rsp.drive_a);
            check_field("drive_b", got_rsp.drive_b, want_rsp.drive_b);
            check_field("effort", got_rsp.effort, want_rsp.effort);
            check_field("logical_position", got_rsp.logical_position,
                        want_rsp.logical_position);
            check_field("velocity", got_rsp.velocity, want_rsp.velocity);
            check_field("saturated", got_rsp.saturated, want_rsp.saturated);
         end
      end
   end

   initial begin
      reset_axis_model();
      // reset settings throughout
      add_row(16'h0000, MODE_OFF, 32'sd0, 19'sd0, 1'b0, 32'sd0, 1'b1, IDLE_RSP);
      add_row(16'h0000, MODE_OPEN, 32'sd0, 19'sh20000, 1'b0, 32'sd0, 1'b1,
              '{13'd4199, 1'b1, 1'b0, 19'sh20000, 32'sd0, 32'sd0, 1'b0});
      add_row(16'h0000, MODE_OPEN, 32'sd0, -19'sd131072, 1'b0, 32'sd0, 1'b1,
              '{13'd4199, 1'b0, 1'b1, -19'sd131072, 32'sd0, 32'sd0, 1'b0});
      add_row(16'h0000, MODE_OPEN, 32'sd0, 19'sd65535, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_OPEN, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_BUSY, 32'sd0, 19'sh20000, 1'b0, 32'sd0, 1'b1, IDLE_RSP);
      add_row(16'h8000, MODE_OFF, 32'sd0, 19'sd0, 1'b1, 32'sh7FFFFFFF, 1'b1,
              '{13'd0, 1'b0, 1'b1, 19'sd0, 32'sh7FFFFFFF, 32'sd0, 1'b0});
      add_row(16'h7FFF, MODE_OFF, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h8000, MODE_OFF, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h8001, MODE_OFF, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_OFF, 32'sd0, 19'sd0, 1'b1, 32'sh80000000, 1'b1,
              '{13'd0, 1'b0, 1'b1, 19'sd0, 32'sh80000000, 32'sd0, 1'b0});
      add_row(16'hFFFF, MODE_OFF, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      // entering position control right on the setpoint: inside the deadband
      add_row(16'h0000, MODE_POS, 32'sd0, 19'sd0, 1'b1, 32'sd0, 1'b1, IDLE_RSP);
      add_row(16'h0000, MODE_POS, 32'sd1, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_POS, 32'sd100, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_POS, 32'sh7FFFFFFF, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_POS, 32'sh80000000, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h0000, MODE_OPEN, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h7FFF, MODE_POS, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h8000, MODE_POS, -32'sd5, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h8000, MODE_BUSY, 32'sd0, 19'sd0, 1'b0, 32'sd0);
      add_row(16'h1234, MODE_POS, 32'sd1000, 19'sd0, 1'b1, 32'sd990);
      add_row(16'h5555, MODE_OFF, 32'shAAAAAAAA, 19'sh2AAAA, 1'b0, 32'sh55555555);
      add_row(16'h5555, MODE_OPEN, 32'sd0, 19'sd1, 1'b0, 32'sd0);
      add_row(16'h5555, MODE_OPEN, 32'sd0, -19'sd1, 1'b0, 32'sd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].want);
      enc_now = 16'h5555;

      for (int ph = 0; ph < 12; ph++) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         @(posedge clock);
         while (tick_results.size() != 0) @(posedge clock);
         load_settings(random_settings(ph));
         target_now = 32'(pos_counts());
         for (int k = 0; k < 170; k++) send_word(random_tick());
      end

      req_tvalid <= 1'b0;
      while (tick_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
